// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define BPA_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");
`define BPA_CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");
`endif

// File: rtl/bpa_pkg.sv
// Types, codes and constants of the buddy page allocator.
// Used by every module of the block; depends on nothing.
package bpa_pkg;
  localparam int OFFW       = 22;
  localparam int REQW       = 23;
  localparam int PAGEW      = 11;
  localparam int LVW        = 4;
  localparam int FUNCW      = 2;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
  localparam int PGW        = OFFW - PAGE_SHIFT;
  localparam int PCW        = REQW + 1 - PAGE_SHIFT;
  localparam logic [LVW-1:0] LEVEL_RESET = 4'd10;

  typedef enum logic [1:0] {
    FN_ALLOC  = 2'd0,
    FN_FREE   = 2'd1,
    FN_QPAGES = 2'd2,
    FN_QUSED  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ND_UNUSED = 2'd0,
    ND_USED   = 2'd1,
    ND_SPLIT  = 2'd2,
    ND_FULL   = 2'd3
  } node_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOTBLK  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    IX_LEFT    = 2'd0,
    IX_RIGHT   = 2'd1,
    IX_PARENT  = 2'd2,
    IX_SIBLING = 2'd3
  } ix_op_t;

  typedef struct packed {
    logic  st_we;
    logic  ub_we;
    node_t st_data;
  } mem_wr_t;

  typedef struct packed {
    status_t           status;
    logic [OFFW-1:0]   block_offset;
    logic [PAGEW-1:0]  block_pages;
    logic [REQW-1:0]   used_bytes;
  } res_t;

  function automatic logic [LVW-1:0] ceil_log2(input logic [PCW-1:0] v);
    logic [LVW-1:0] r;
    r = '0;
    for (int i = 0; i < PCW; i++) begin
      if (v > (PCW'(1) << i)) r = LVW'(i + 1);
    end
    return r;
  endfunction
endpackage

// File: rtl/bpa_node_mem.sv
// Node state store and recorded-bytes store of the buddy tree.
// One write and one registered read per cycle; depends on bpa_pkg.
module bpa_node_mem import bpa_pkg::*; #(
  parameter int AW = 11
) (
  input  logic            clk,
  input  logic [AW-1:0]   rd_addr,
  input  logic [AW-1:0]   wr_addr,
  input  mem_wr_t         wr,
  input  logic [REQW-1:0] ub_wdata,
  output node_t           st_rd_r,
  output logic [REQW-1:0] ub_rd_r
);
  localparam int DEPTH = (2 ** AW) - 1;

  node_t           st_mem [DEPTH];
  logic [REQW-1:0] ub_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.st_we) st_mem[wr_addr] <= wr.st_data;
    if (wr.ub_we) ub_mem[wr_addr] <= ub_wdata;
    st_rd_r <= st_mem[rd_addr];
    ub_rd_r <= ub_mem[rd_addr];
  end
endmodule

// File: rtl/bpa_idx_unit.sv
// Shared node index unit: child, parent and buddy of a tree node.
// Pure logic used by the sequencer each cycle; depends on bpa_pkg.
module bpa_idx_unit import bpa_pkg::*; #(
  parameter int AW = 11
) (
  input  logic [AW-1:0] idx,
  input  ix_op_t        op,
  output logic [AW-1:0] nxt
);
  logic [AW-1:0] left;

  assign left = {idx[AW-2:0], 1'b1};

  always_comb begin
    unique case (op)
      IX_LEFT:    nxt = left;
      IX_RIGHT:   nxt = left + AW'(1);
      IX_PARENT:  nxt = (idx - AW'(1)) >> 1;
      IX_SIBLING: nxt = idx[0] ? idx + AW'(1) : idx - AW'(1);
      default:    nxt = left;
    endcase
  end
endmodule

// File: rtl/bpa_ctrl.sv
// Sequencer of the buddy allocator: clear pass, search, walk, mark and merge.
// Drives the node stores and the index unit; depends on bpa_pkg.
module bpa_ctrl import bpa_pkg::*; #(
  parameter int TREE_LEVELS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNCW-1:0]     in_func,
  input  logic [REQW-1:0]      in_req_bytes,
  input  logic [OFFW-1:0]      in_offset,
  input  logic [LVW-1:0]       level,
  input  logic                 cfg_we,
  output logic                 res_valid,
  output res_t                 res,
  input  logic                 res_taken,
  output ix_op_t               ix_op,
  output logic [TREE_LEVELS:0] ix_idx,
  input  logic [TREE_LEVELS:0] ix_nxt,
  output logic [TREE_LEVELS:0] rd_addr,
  output logic [TREE_LEVELS:0] wr_addr,
  output mem_wr_t              wr,
  output logic [REQW-1:0]      ub_wdata,
  input  node_t                st_rd,
  input  logic [REQW-1:0]      ub_rd
);
  localparam int AW = TREE_LEVELS + 1;
  localparam logic [AW-1:0] LAST = AW'((2 ** AW) - 2);

  typedef enum logic [20:0] {
    S_CLEAR   = 21'h000001,
    S_IDLE    = 21'h000002,
    S_A_RD    = 21'h000004,
    S_A_EV    = 21'h000008,
    S_A_BT    = 21'h000010,
    S_A_FRESH = 21'h000020,
    S_A_DOWN  = 21'h000040,
    S_M_CHK   = 21'h000080,
    S_M_RD    = 21'h000100,
    S_M_EV    = 21'h000200,
    S_L_RD    = 21'h000400,
    S_L_EV    = 21'h000800,
    S_U_RD    = 21'h001000,
    S_U_EV    = 21'h002000,
    S_F_CHK   = 21'h004000,
    S_F_RD    = 21'h008000,
    S_F_EV    = 21'h010000,
    S_F_UP    = 21'h020000,
    S_F_RD2   = 21'h040000,
    S_F_EV2   = 21'h080000,
    S_RESP    = 21'h100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [LVW-1:0]         d_r, d_nxt;
  logic [LVW-1:0]         tgt_r, tgt_nxt;
  logic [LVW-1:0]         lg_r, lg_nxt;
  func_t                  func_r, func_nxt;
  logic [REQW-1:0]        req_r, req_nxt;
  logic [TREE_LEVELS-1:0] pg_r, pg_nxt;
  res_t                   res_r, res_nxt;

  logic [LVW-1:0]             lev, rem, lg_in;
  logic [REQW:0]              page_sum;
  logic [PGW-1:0]             pg_full;
  logic [PGW+TREE_LEVELS-1:0] pg_wide;
  logic [TREE_LEVELS:0]       low_mask;
  logic [TREE_LEVELS-1:0]     pg_sh;
  logic [(2**LVW)-1:0]        pw_rem, pw_lg;
  logic [AW-1:0]              fnd_idx, first, pidx;
  logic [AW+OFFW-1:0]         boff_w;

  assign lev      = (level > TREE_LEVELS) ? LVW'(TREE_LEVELS) : level;
  assign rem      = lev - d_r;
  assign page_sum = (REQW+1)'(in_req_bytes) + (REQW+1)'(PAGE_BYTES - 1);
  assign lg_in    = ceil_log2(page_sum[REQW:PAGE_SHIFT]);
  assign pg_full  = in_offset[OFFW-1:PAGE_SHIFT];
  assign pg_wide  = (PGW+TREE_LEVELS)'(pg_full);
  assign low_mask = ((TREE_LEVELS+1)'(1) << rem) - (TREE_LEVELS+1)'(1);
  assign pg_sh    = pg_r >> LVW'(rem - 1'b1);
  assign pw_rem   = (2**LVW)'(1) << rem;
  assign pw_lg    = (2**LVW)'(1) << lg_r;
  assign first    = fnd_idx + AW'(1) - (AW'(1) << tgt_r);
  assign pidx     = first << lg_r;
  assign boff_w   = (AW+OFFW)'(pidx) << PAGE_SHIFT;

  assign ix_idx    = idx_r;
  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;
  assign ub_wdata  = req_r;
  assign rd_addr   = (state_r == S_M_RD || state_r == S_F_RD) ? ptr_r : idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ptr_nxt   = ptr_r;
    d_nxt     = d_r;
    tgt_nxt   = tgt_r;
    lg_nxt    = lg_r;
    func_nxt  = func_r;
    req_nxt   = req_r;
    pg_nxt    = pg_r;
    res_nxt   = res_r;
    ix_op     = IX_LEFT;
    wr        = '{st_we: 1'b0, ub_we: 1'b0, st_data: ND_UNUSED};
    wr_addr   = idx_r;
    fnd_idx   = idx_r;
    if (state_r == S_A_DOWN) fnd_idx = ix_nxt;
    unique case (state_r)
      S_CLEAR: begin
        wr.st_we = 1'b1;
        if (idx_r == LAST) state_nxt = S_IDLE;
        else idx_nxt = idx_r + AW'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = func_t'(in_func);
          req_nxt  = in_req_bytes;
          pg_nxt   = pg_wide[TREE_LEVELS-1:0];
          idx_nxt  = '0;
          d_nxt    = '0;
          lg_nxt   = lg_in;
          tgt_nxt  = lev - lg_in;
          res_nxt  = '{status: ST_OK, default: '0};
          if (func_t'(in_func) == FN_ALLOC) begin
            if (lg_in > lev) begin
              res_nxt.status = ST_NOSPACE;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_A_RD;
            end
          end else if ((pg_full >> lev) != '0) begin
            res_nxt.status = ST_RANGE;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_L_RD;
          end
        end
      end
      S_A_RD: state_nxt = S_A_EV;
      S_A_EV: begin
        if (d_r == tgt_r) begin
          if (st_rd == ND_UNUSED) begin
            wr        = '{st_we: 1'b1, ub_we: 1'b1, st_data: ND_USED};
            state_nxt = S_M_CHK;
          end else begin
            state_nxt = S_A_BT;
          end
        end else if (st_rd == ND_USED || st_rd == ND_FULL) begin
          state_nxt = S_A_BT;
        end else if (st_rd == ND_SPLIT) begin
          ix_op     = IX_LEFT;
          idx_nxt   = ix_nxt;
          d_nxt     = d_r + 1'b1;
          state_nxt = S_A_RD;
        end else begin
          wr        = '{st_we: 1'b1, ub_we: 1'b0, st_data: ND_SPLIT};
          state_nxt = S_A_FRESH;
        end
      end
      S_A_BT: begin
        if (idx_r == '0) begin
          res_nxt.status = ST_NOSPACE;
          state_nxt      = S_RESP;
        end else if (idx_r[0]) begin
          ix_op     = IX_SIBLING;
          idx_nxt   = ix_nxt;
          state_nxt = S_A_RD;
        end else begin
          ix_op   = IX_PARENT;
          idx_nxt = ix_nxt;
          d_nxt   = d_r - 1'b1;
        end
      end
      S_A_FRESH: begin
        ix_op     = IX_RIGHT;
        wr        = '{st_we: 1'b1, ub_we: 1'b0, st_data: ND_UNUSED};
        wr_addr   = ix_nxt;
        state_nxt = S_A_DOWN;
      end
      S_A_DOWN: begin
        ix_op   = IX_LEFT;
        idx_nxt = ix_nxt;
        d_nxt   = d_r + 1'b1;
        wr_addr = ix_nxt;
        if (LVW'(d_r + 1'b1) == tgt_r) begin
          wr        = '{st_we: 1'b1, ub_we: 1'b1, st_data: ND_USED};
          state_nxt = S_M_CHK;
        end else begin
          wr        = '{st_we: 1'b1, ub_we: 1'b0, st_data: ND_SPLIT};
          state_nxt = S_A_FRESH;
        end
      end
      S_M_CHK: begin
        if (idx_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          ix_op     = IX_SIBLING;
          ptr_nxt   = ix_nxt;
          state_nxt = S_M_RD;
        end
      end
      S_M_RD: state_nxt = S_M_EV;
      S_M_EV: begin
        if (st_rd == ND_USED || st_rd == ND_FULL) begin
          ix_op     = IX_PARENT;
          idx_nxt   = ix_nxt;
          wr        = '{st_we: 1'b1, ub_we: 1'b0, st_data: ND_FULL};
          wr_addr   = ix_nxt;
          state_nxt = S_M_CHK;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_L_RD: state_nxt = S_L_EV;
      S_L_EV: begin
        if (st_rd == ND_USED) begin
          if ((pg_r & low_mask[TREE_LEVELS-1:0]) != '0) begin
            res_nxt.status = ST_NOTBLK;
            state_nxt      = S_RESP;
          end else begin
            unique case (func_r)
              FN_FREE:   state_nxt = S_F_CHK;
              FN_QPAGES: begin
                res_nxt.block_pages = pw_rem[PAGEW-1:0];
                state_nxt           = S_RESP;
              end
              FN_QUSED:  state_nxt = S_U_RD;
              default:   state_nxt = S_RESP;
            endcase
          end
        end else if (st_rd == ND_UNUSED || d_r >= lev) begin
          res_nxt.status = ST_NOTBLK;
          state_nxt      = S_RESP;
        end else begin
          ix_op     = pg_sh[0] ? IX_RIGHT : IX_LEFT;
          idx_nxt   = ix_nxt;
          d_nxt     = d_r + 1'b1;
          state_nxt = S_L_RD;
        end
      end
      S_U_RD: state_nxt = S_U_EV;
      S_U_EV: begin
        res_nxt.used_bytes = ub_rd;
        state_nxt          = S_RESP;
      end
      S_F_CHK: begin
        if (idx_r == '0) begin
          wr        = '{st_we: 1'b1, ub_we: 1'b0, st_data: ND_UNUSED};
          state_nxt = S_RESP;
        end else begin
          ix_op     = IX_SIBLING;
          ptr_nxt   = ix_nxt;
          state_nxt = S_F_RD;
        end
      end
      S_F_RD: state_nxt = S_F_EV;
      S_F_EV: begin
        if (st_rd == ND_UNUSED) begin
          ix_op     = IX_PARENT;
          idx_nxt   = ix_nxt;
          state_nxt = S_F_CHK;
        end else begin
          wr        = '{st_we: 1'b1, ub_we: 1'b0, st_data: ND_UNUSED};
          state_nxt = S_F_UP;
        end
      end
      S_F_UP: begin
        if (idx_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          ix_op     = IX_PARENT;
          idx_nxt   = ix_nxt;
          state_nxt = S_F_RD2;
        end
      end
      S_F_RD2: state_nxt = S_F_EV2;
      S_F_EV2: begin
        if (st_rd == ND_FULL) begin
          wr        = '{st_we: 1'b1, ub_we: 1'b0, st_data: ND_SPLIT};
          state_nxt = S_F_UP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_taken) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (wr.ub_we) begin
      idx_nxt              = fnd_idx;
      res_nxt.block_offset = boff_w[OFFW-1:0];
      res_nxt.block_pages  = pw_lg[PAGEW-1:0];
    end
    if (cfg_we) begin
      state_nxt = S_CLEAR;
      idx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    d_r    <= d_nxt;
    tgt_r  <= tgt_nxt;
    lg_r   <= lg_nxt;
    func_r <= func_nxt;
    req_r  <= req_nxt;
    pg_r   <= pg_nxt;
    res_r  <= res_nxt;
  end
endmodule

// File: rtl/buddy_page_allocator_unit.sv
// Buddy page allocator: one request word in, one result word out.
// Alloc: a depth-first search over the tree nodes, then marking of full ancestors.
// Free and queries: a walk down the levels; the used-bytes query then reads the recorded
// bytes; free merges buddies and turns full ancestors back to split; then the result goes out.
// One word in the sequencer, one result at the output; the node store's single read port
// and the sequencer set the pace. Reset and each level write clear the store, input stalled.
`include "assert_macros.svh"
module buddy_page_allocator_unit import bpa_pkg::*; #(
  parameter int TREE_LEVELS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LVW-1:0]    cfg_level_in_use,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNCW-1:0]  in_func,
  input  logic [REQW-1:0]   in_req_bytes,
  input  logic [OFFW-1:0]   in_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [OFFW-1:0]   out_block_offset,
  output logic [PAGEW-1:0]  out_block_pages,
  output logic [REQW-1:0]   out_used_bytes
);
  localparam int AW = TREE_LEVELS + 1;

  logic [LVW-1:0] level_r, level_nxt;
  logic           out_valid_r, out_valid_nxt;
  res_t           out_r;
  logic           res_valid, res_taken;
  res_t           res;
  ix_op_t         ix_op;
  logic [AW-1:0]  ix_idx, ix_nxt, rd_addr, wr_addr;
  mem_wr_t        wr;
  logic [REQW-1:0] ub_wdata, ub_rd;
  node_t          st_rd;

  assign res_taken     = res_valid && (!out_valid_r || !out_stall);
  assign level_nxt     = cfg_we ? cfg_level_in_use : level_r;
  assign out_valid_nxt = res_taken || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LEVEL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) out_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_block_offset = out_r.block_offset;
  assign out_block_pages  = out_r.block_pages;
  assign out_used_bytes   = out_r.used_bytes;

  bpa_ctrl #(.TREE_LEVELS(TREE_LEVELS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_req_bytes (in_req_bytes),
    .in_offset    (in_offset),
    .level        (level_r),
    .cfg_we       (cfg_we),
    .res_valid    (res_valid),
    .res          (res),
    .res_taken    (res_taken),
    .ix_op        (ix_op),
    .ix_idx       (ix_idx),
    .ix_nxt       (ix_nxt),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr           (wr),
    .ub_wdata     (ub_wdata),
    .st_rd        (st_rd),
    .ub_rd        (ub_rd)
  );

  bpa_idx_unit #(.AW(AW)) u_idx (
    .idx (ix_idx),
    .op  (ix_op),
    .nxt (ix_nxt)
  );

  bpa_node_mem #(.AW(AW)) u_mem (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr       (wr),
    .ub_wdata (ub_wdata),
    .st_rd_r  (st_rd),
    .ub_rd_r  (ub_rd)
  );

  `BPA_CHK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `BPA_CHK_NEXT(a_clear_after_cfg, cfg_we, in_stall)
  `BPA_CHK_SAME(a_out_from_seq, $rose(out_valid_r), $past(res_valid))
endmodule

// File: tb/buddy_page_allocator_unit_tb.sv
// Self-checking testbench of the buddy page allocator unit: directed and random request
// words, random stalls on both sides, results checked against a built-in allocator model.
// Depends on bpa_pkg and buddy_page_allocator_unit.
module buddy_page_allocator_unit_tb;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXLV = 10;
  localparam int NODES = (2 << MAXLV) - 1;
  localparam longint LIMIT = 40000000;

  class alloc_scoreboard;
    node_t            node_st[NODES];
    logic [REQW-1:0]  node_ub[NODES];
    logic [LVW-1:0]   level;
    res_t             pending[$];
    int               errors;
    int               mismatches;

    function new();
      level = LEVEL_RESET;
      clear_tree();
      errors = 0;
      mismatches = 0;
    endfunction

    function void clear_tree();
      for (int i = 0; i < NODES; i++) begin
        node_st[i] = ND_UNUSED;
        node_ub[i] = '0;
      end
    endfunction

    function void set_level(logic [LVW-1:0] v);
      level = v;
      clear_tree();
    endfunction

    function int eff_level();
      return (level > MAXLV) ? MAXLV : int'(level);
    endfunction

    function int buddy(int i);
      return (i % 2 == 1) ? i + 1 : i - 1;
    endfunction

    function int find_free(int tgt);
      int stk_i[$];
      int stk_d[$];
      int i;
      int d;
      stk_i.push_back(0);
      stk_d.push_back(0);
      while (stk_i.size() > 0) begin
        i = stk_i.pop_back();
        d = stk_d.pop_back();
        if (d == tgt) begin
          if (node_st[i] == ND_UNUSED) return i;
        end else if (node_st[i] != ND_USED && node_st[i] != ND_FULL) begin
          if (node_st[i] == ND_UNUSED) begin
            node_st[i] = ND_SPLIT;
            node_st[2*i+1] = ND_UNUSED;
            node_st[2*i+2] = ND_UNUSED;
          end
          stk_i.push_back(2*i+2);
          stk_d.push_back(d+1);
          stk_i.push_back(2*i+1);
          stk_d.push_back(d+1);
        end
      end
      return -1;
    endfunction

    function res_t note(func_t fn, logic [REQW-1:0] req, logic [OFFW-1:0] off);
      res_t r;
      int lev;
      int lg;
      int tgt;
      int idx;
      int d;
      longint pages;
      longint sz;
      longint pg;
      longint left;
      longint len;
      bit done;
      r = '0;
      r.status = ST_OK;
      lev = eff_level();
      if (fn == FN_ALLOC) begin
        pages = (longint'(req) + PAGE_BYTES - 1) / PAGE_BYTES;
        sz = 1;
        lg = 0;
        while (sz < pages) begin
          sz = sz << 1;
          lg++;
        end
        if (lg > lev) begin
          r.status = ST_NOSPACE;
        end else begin
          tgt = lev - lg;
          idx = find_free(tgt);
          if (idx < 0) begin
            r.status = ST_NOSPACE;
          end else begin
            node_st[idx] = ND_USED;
            node_ub[idx] = req;
            r.block_offset =
              OFFW'(((longint'(idx) + 1 - (longint'(1) << tgt)) << lg) * PAGE_BYTES);
            r.block_pages = PAGEW'(sz);
            while (idx != 0 && (node_st[buddy(idx)] == ND_USED || node_st[buddy(idx)] == ND_FULL))
            begin
              idx = (idx - 1) / 2;
              node_st[idx] = ND_FULL;
            end
          end
        end
      end else begin
        pg = longint'(off) / PAGE_BYTES;
        left = 0;
        len = longint'(1) << lev;
        idx = 0;
        d = 0;
        done = 0;
        if (pg >= len) begin
          r.status = ST_RANGE;
          done = 1;
        end
        while (!done) begin
          if (node_st[idx] == ND_USED) begin
            done = 1;
            if (pg != left) begin
              r.status = ST_NOTBLK;
            end else if (fn == FN_QPAGES) begin
              r.block_pages = PAGEW'(len);
            end else if (fn == FN_QUSED) begin
              r.used_bytes = node_ub[idx];
            end else begin
              while (idx != 0 && node_st[buddy(idx)] == ND_UNUSED) idx = (idx - 1) / 2;
              node_st[idx] = ND_UNUSED;
              while (idx != 0) begin
                idx = (idx - 1) / 2;
                if (node_st[idx] != ND_FULL) break;
                node_st[idx] = ND_SPLIT;
              end
            end
          end else if (node_st[idx] == ND_UNUSED || d >= lev) begin
            r.status = ST_NOTBLK;
            done = 1;
          end else begin
            len = len >> 1;
            if (pg < left + len) begin
              idx = 2*idx + 1;
            end else begin
              left = left + len;
              idx = 2*idx + 2;
            end
            d++;
          end
        end
      end
      pending.push_back(r);
      return r;
    endfunction

    function void check(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("unexpected result word: %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected st=%0d off=%0d pg=%0d ub=%0d",
                    " got st=%0d off=%0d pg=%0d ub=%0d"},
                   e.status, e.block_offset, e.block_pages, e.used_bytes,
                   got.status, got.block_offset, got.block_pages, got.used_bytes);
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [LVW-1:0]    cfg_level_in_use = '0;
  logic              in_valid = 0;
  logic              in_stall;
  logic [FUNCW-1:0]  in_func = '0;
  logic [REQW-1:0]   in_req_bytes = '0;
  logic [OFFW-1:0]   in_offset = '0;
  logic              out_valid;
  logic              out_stall = 0;
  logic [1:0]        out_status;
  logic [OFFW-1:0]   out_block_offset;
  logic [PAGEW-1:0]  out_block_pages;
  logic [REQW-1:0]   out_used_bytes;

  alloc_scoreboard sb = new();
  int tx_pct = 0;
  int rx_pct = 0;
  int hold_left = 0;
  bit hold_req = 0;
  longint cycles = 0;
  logic [OFFW-1:0] live[$];

  buddy_page_allocator_unit #(.TREE_LEVELS(MAXLV)) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_level_in_use(cfg_level_in_use),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_req_bytes(in_req_bytes), .in_offset(in_offset),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_offset(out_block_offset), .out_block_pages(out_block_pages),
    .out_used_bytes(out_used_bytes)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("buddy_page_allocator_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status = status_t'(out_status);
        got.block_offset = out_block_offset;
        got.block_pages = out_block_pages;
        got.used_bytes = out_used_bytes;
        sb.check(got);
      end
      if (hold_req) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_pct);
      end
    end
  end

  task automatic send_word(func_t fn, logic [REQW-1:0] req, logic [OFFW-1:0] off);
    res_t r;
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_req_bytes <= req;
    in_offset <= off;
    do @(posedge clk); while (in_stall);
    r = sb.note(fn, req, off);
    if (fn == FN_ALLOC && r.status == ST_OK) live.push_back(r.block_offset);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_level(logic [LVW-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_level_in_use <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_level(v);
    live.delete();
  endtask

  task automatic random_word();
    int k;
    int sel;
    int s;
    logic [OFFW-1:0] o;
    k = $urandom_range(0, 99);
    s = $urandom_range(0, 23);
    if (k < 40) begin
      send_word(FN_ALLOC, REQW'($urandom & ((1 << s) - 1)), OFFW'($urandom));
    end else if (k < 80 && live.size() > 0) begin
      sel = $urandom_range(0, live.size() - 1);
      o = live[sel];
      if ($urandom_range(0, 3) == 0) o = o + OFFW'($urandom_range(0, PAGE_BYTES - 1));
      if (k < 62) begin
        send_word(FN_FREE, REQW'($urandom), o);
        live.delete(sel);
      end else begin
        send_word(func_t'($urandom_range(2, 3)), REQW'($urandom), o);
      end
    end else begin
      send_word(func_t'($urandom_range(0, 3)), REQW'($urandom), OFFW'($urandom));
    end
  endtask

  initial begin
    logic [LVW-1:0] levels[7] = '{4'd10, 4'd0, 4'd15, 4'd3, 4'd10, 4'd1, 4'd7};
    int done_items;
    done_items = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(FN_ALLOC, 23'd0, '0);
    send_word(FN_ALLOC, 23'd1, '0);
    send_word(FN_ALLOC, 23'd4096, '0);
    send_word(FN_ALLOC, 23'd4097, '0);
    send_word(FN_ALLOC, 23'h7FFFFF, '0);
    send_word(FN_ALLOC, 23'd4194304, '0);
    send_word(FN_QPAGES, '0, 22'd0);
    send_word(FN_QUSED, '0, 22'd8192);
    send_word(FN_QUSED, '0, 22'h3FFFFF);
    send_word(FN_FREE, '0, 22'd4096);
    send_word(FN_FREE, '0, 22'd0);
    send_word(FN_FREE, '0, 22'd0);
    send_word(FN_QPAGES, '0, 22'd16384);
    send_word(FN_FREE, '0, 22'd8192);
    send_word(FN_FREE, '0, 22'd16384);
    send_word(FN_ALLOC, 23'd4194304, '0);
    send_word(FN_QPAGES, '0, 22'd12288);
    write_level(4'd0);
    send_word(FN_ALLOC, 23'd1, '0);
    send_word(FN_ALLOC, 23'd1, '0);
    send_word(FN_QUSED, '0, 22'd0);
    send_word(FN_QPAGES, '0, 22'd4096);
    send_word(FN_FREE, '0, 22'd0);
    write_level(4'd15);
    send_word(FN_ALLOC, 23'd4194304, '0);
    send_word(FN_QPAGES, '0, 22'd0);

    for (int p = 0; p < 7; p++) begin
      write_level(levels[p]);
      for (int n = 0; n < 130; n++) begin
        if (done_items < 300) begin
          tx_pct = 22;
          rx_pct = 85;
        end else if (done_items < 600) begin
          tx_pct = 85;
          rx_pct = 22;
        end else begin
          tx_pct = 0;
          rx_pct = 0;
        end
        if (done_items == 450) hold_req = 1;
        if (done_items == 500) drain();
        random_word();
        done_items++;
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("buddy_page_allocator_unit test passed");
    end else begin
      $display("buddy_page_allocator_unit test failed");
    end
    $finish;
  end
endmodule
